>>> rtl/core/nat_pkg.sv
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types and codes for the neighbour aging table.
// ----------------------------------------------------------------------------
package nat_pkg;

    // action carried in the input tuser
    localparam logic ACT_REFRESH = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    localparam int unsigned ID_W      = 32;
    localparam int unsigned CTR_W     = 16;
    localparam int unsigned CNT_W     = 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [CTR_W-1:0] TIMEOUT_RESET = 16'd3;

    typedef enum logic [1:0] {
        ST_REFRESHED = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_TICK      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_INSERT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] removed;
    } t_result;

endpackage

>>> rtl/core/nat_ram.sv
// ----------------------------------------------------------------------------
// nat_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nat_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/nat_ctrl.sv
// ----------------------------------------------------------------------------
// nat_ctrl
// Table walker: index sequencer, valid bits, id/counter RAMs and the one
// shared compare/decrement unit.
// ----------------------------------------------------------------------------
module nat_ctrl #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_action,
    input  logic [31:0]      i_id,
    input  logic [15:0]      i_timeout,
    input  logic             i_res_take,
    output logic             o_ready,
    output logic             o_res_valid,
    output nat_pkg::t_result o_res
);
    import nat_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    t_state           r_state, n_state;
    logic             r_action, n_action;
    logic [ID_W-1:0]  r_id, n_id;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_chk_vld, n_chk_vld;
    logic [IW-1:0]    r_chk_idx, n_chk_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic             r_free_found, n_free_found;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    logic [CNT_W-1:0] r_removed, n_removed;
    t_status          r_status, n_status;

    logic             id_we, ctr_we;
    logic [IW-1:0]    wr_addr;
    logic [CTR_W-1:0] wr_ctr;
    logic [ID_W-1:0]  id_rdata;
    logic [CTR_W-1:0] ctr_rdata;

    // shared unit
    logic             id_hit, ctr_zero;
    logic [CTR_W-1:0] ctr_dec;

    assign id_hit   = (id_rdata == r_id);
    assign ctr_zero = (ctr_rdata == '0);
    assign ctr_dec  = ctr_rdata - CTR_W'(1);

    nat_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (wr_addr),
        .i_wdata (r_id),
        .i_raddr (r_idx),
        .o_rdata (id_rdata)
    );

    nat_ram #(.WIDTH(CTR_W), .DEPTH(ENTRIES)) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_ctr),
        .i_raddr (r_idx),
        .o_rdata (ctr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_issue   <= n_issue;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_id         <= n_id;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_removed    <= n_removed;
        r_status     <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_id         = r_id;
        n_idx        = r_idx;
        n_issue      = r_issue;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_valid      = r_valid;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_removed    = r_removed;
        n_status     = r_status;
        id_we        = 1'b0;
        ctr_we       = 1'b0;
        wr_addr      = r_chk_idx;
        wr_ctr       = i_timeout;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action     = i_action;
                    n_id         = i_id;
                    n_idx        = '0;
                    n_issue      = 1'b1;
                    n_chk_vld    = 1'b0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    n_state      = S_WALK;
                end
            end
            S_WALK: begin
                // read issue, one entry ahead of the check
                n_chk_vld = r_issue;
                n_chk_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_chk_vld) begin
                    if (r_action == ACT_REFRESH) begin
                        if (r_valid[r_chk_idx] && id_hit) begin
                            ctr_we    = 1'b1;
                            n_status  = ST_REFRESHED;
                            n_issue   = 1'b0;
                            n_chk_vld = 1'b0;
                            n_state   = S_EMIT;
                        end else begin
                            if (!r_valid[r_chk_idx] && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_chk_idx;
                            end
                            if (r_chk_idx == LAST) begin
                                n_state = S_INSERT;
                            end
                        end
                    end else begin
                        if (r_valid[r_chk_idx]) begin
                            if (ctr_zero) begin
                                n_valid[r_chk_idx] = 1'b0;
                                if (r_removed != COUNT_MAX) begin
                                    n_removed = r_removed + CNT_W'(1);
                                end
                            end else begin
                                ctr_we = 1'b1;
                                wr_ctr = ctr_dec;
                            end
                        end
                        if (r_chk_idx == LAST) begin
                            n_status = ST_TICK;
                            n_state  = S_EMIT;
                        end
                    end
                end
            end
            S_INSERT: begin
                if (r_free_found) begin
                    id_we               = 1'b1;
                    ctr_we              = 1'b1;
                    wr_addr             = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_status            = ST_INSERTED;
                end else begin
                    n_status = ST_DROPPED;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_EMIT);
    assign o_res.status   = r_status;
    assign o_res.removed  = r_removed;

endmodule

>>> rtl/core/neighbor_aging_table_unit.sv
// ----------------------------------------------------------------------------
// neighbor_aging_table_unit
// Neighbour ID table with per-entry aging counters, walked entry by entry.
// ----------------------------------------------------------------------------
// Walk: a tick visits every entry; a refresh stops at the entry that hits,
//   or walks every entry and then inserts into the first free one.
// Throughput: one item at a time; the next is accepted once the walker is idle.
//   The walk reads one entry per cycle through the RAM read ports and the shared unit.
// Reset (synchronous, i_rst_n low): all entries invalid, timeout back to 3,
//   output beat dropped. ID and counter RAMs are not cleared.
// ----------------------------------------------------------------------------
module neighbor_aging_table_unit #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: timeout_ticks
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] peer_id
    input  logic        s_axis_tuser,   // [0] action
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] removed_count, [7:5] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import nat_pkg::*;

    logic [CTR_W-1:0] r_timeout;
    logic             r_out_vld;
    t_result          r_out;

    logic    start, res_valid, res_take, ctrl_ready;
    t_result res;

    // config taken only while the walker is idle, so an item in flight keeps
    // the timeout it started with
    assign o_cfg_ready = ctrl_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && ctrl_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign s_axis_tready = ctrl_ready;
    assign start         = s_axis_tvalid && ctrl_ready;

    nat_ctrl #(.ENTRIES(TABLE_ENTRIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (s_axis_tuser),
        .i_id        (s_axis_tdata),
        .i_timeout   (r_timeout),
        .i_res_take  (res_take),
        .o_ready     (ctrl_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register: parts the walker from the sink, so the next item can
    // start while a result waits
    assign res_take = res_valid && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out.removed};
    assign m_axis_tuser  = r_out.status;

endmodule

>>> rtl/core/nat_checker.sv
// ----------------------------------------------------------------------------
// nat_checker
// Port-level checks on the neighbour aging table, bound to the top level.
// ----------------------------------------------------------------------------
module nat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import nat_pkg::*;

    // one item at a time: no accept straight after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while item in progress");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

    // only a tick reports removals; padding bits stay zero
    a_count_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_TICK)) |-> (m_axis_tdata == 8'd0))
        else $error("removed count on non-tick result");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind neighbor_aging_table_unit nat_checker u_nat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
